[rtl/crc8_packet_deframer_macros.svh]
// Assertion macros for the deframer modules (used by the result queue).
`ifndef CRC8_PACKET_DEFRAMER_MACROS_SVH
`define CRC8_PACKET_DEFRAMER_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define CRC8PD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define CRC8PD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/crc8pd_pkg.sv]
package crc8pd_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgHeaderByte = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxPayload = 1'b1;

  localparam logic [7:0] HeaderByteReset = 8'h55;
  localparam logic [7:0] MaxPayloadReset = 8'd64;
  localparam logic [7:0] CrcPoly = 8'h07;

  localparam logic KindByte    = 1'b0;
  localparam logic KindTimeout = 1'b1;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_DATA   = 2'd2,
    PH_CRC    = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_PAYLOAD = 2'd0,
    EV_GOOD    = 2'd1,
    EV_BAD     = 2'd2
  } event_e;

  typedef struct packed {
    event_e     event_res;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;
    logic [7:0] command;
    logic [7:0] received_crc;
    logic [7:0] computed_crc;
  } result_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/crc8pd_front.sv]
module crc8pd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crc8pd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          in_kind_i,
  input  logic [7:0]                    in_byte_i,
  output logic                          push_o,
  output crc8pd_pkg::result_t           res_o
);
  import crc8pd_pkg::*;

  logic [7:0] header_q;
  logic [7:0] max_payload_q;

  phase_e     phase_q, phase_d;
  logic [7:0] remaining_q, remaining_d;
  logic [7:0] length_q, length_d;
  logic [7:0] crc_q, crc_d;
  logic [7:0] first_q, first_d;

  logic       fire;
  logic [7:0] byte_idx;
  logic [7:0] rem_dec;

  assign fire     = in_valid_i & in_ready_i;
  assign byte_idx = length_q - remaining_q;
  assign rem_dec  = (remaining_q != 8'd0) ? remaining_q - 8'd1 : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q      <= HeaderByteReset;
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgHeaderByte: header_q      <= cfg_data_i;
        CfgMaxPayload: max_payload_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      remaining_q <= 8'd0;
      length_q    <= 8'd0;
      crc_q       <= 8'd0;
      first_q     <= 8'd0;
    end else begin
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      length_q    <= length_d;
      crc_q       <= crc_d;
      first_q     <= first_d;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    length_d    = length_q;
    crc_d       = crc_q;
    first_d     = first_q;
    push_o      = 1'b0;
    res_o       = '0;
    if (fire) begin
      if (in_kind_i == KindTimeout) begin
        phase_d     = PH_HEADER;
        remaining_d = 8'd0;
        length_d    = 8'd0;
        crc_d       = 8'd0;
        first_d     = 8'd0;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            if (in_byte_i == header_q) begin
              phase_d = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            if (in_byte_i > max_payload_q) begin
              phase_d     = PH_HEADER;
              remaining_d = 8'd0;
              length_d    = 8'd0;
              crc_d       = 8'd0;
              first_d     = 8'd0;
            end else begin
              length_d    = in_byte_i;
              remaining_d = in_byte_i;
              crc_d       = 8'd0;
              first_d     = 8'd0;
              phase_d     = (in_byte_i == 8'd0) ? PH_CRC : PH_DATA;
            end
          end
          PH_DATA: begin
            push_o             = 1'b1;
            res_o.event_res    = EV_PAYLOAD;
            res_o.payload_byte = in_byte_i;
            res_o.byte_index   = byte_idx;
            if (byte_idx == 8'd0) begin
              first_d = in_byte_i;
            end
            crc_d       = crc8_update(crc_q, in_byte_i);
            remaining_d = rem_dec;
            if (rem_dec == 8'd0) begin
              phase_d = PH_CRC;
            end
          end
          PH_CRC: begin
            push_o             = 1'b1;
            res_o.event_res    = (in_byte_i == crc_q) ? EV_GOOD : EV_BAD;
            res_o.frame_length = length_q;
            res_o.command      = (length_q == 8'd0) ? 8'd0 : first_q;
            res_o.received_crc = in_byte_i;
            res_o.computed_crc = crc_q;
            phase_d     = PH_HEADER;
            remaining_d = 8'd0;
            length_d    = 8'd0;
            crc_d       = 8'd0;
            first_d     = 8'd0;
          end
        endcase
      end
    end
  end

endmodule

[rtl/crc8pd_queue.sv]
module crc8pd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crc8pd_pkg::result_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                pop_ready_i,
  output crc8pd_pkg::result_t data_o
);
  import crc8pd_pkg::*;

  `include "crc8_packet_deframer_macros.svh"

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             pop;

  assign ready_o = (count_q != QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign pop     = valid_o & pop_ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CRC8PD_ASSERT(a_count_bound, count_q <= QCntW'(QDepth), "queue count exceeds depth")
  `CRC8PD_ASSERT(a_no_overflow, push_i |-> ready_o, "push into a full queue")
  `CRC8PD_ASSERT(a_pop_drains, (pop && !push_i) |=> (count_q == $past(count_q) - 1'b1),
                 "pop without push did not lower the count")
  `CRC8PD_ASSERT(a_push_fills, (push_i && !pop) |=> (count_q == $past(count_q) + 1'b1),
                 "push without pop did not raise the count")

endmodule

[rtl/crc8_packet_deframer.sv]
// Length-prefixed frame parser with CRC-8 check (polynomial 0x07, initial value 0).
// Input stream: tdata carries a received byte, tuser marks a timeout transaction
// that aborts the frame in progress. Configuration writes (index 0 header byte,
// index 1 largest payload length) are taken at any edge with cfg_we_i high.
// Output stream: one transaction per payload byte and one per CRC byte, tuser
// holding the event code (payload, good CRC, bad CRC). Header, length and
// timeout transactions produce no output.
// Each result is registered in the result queue and is presented once the results
// ahead of it are taken. Throughput: one input transaction per cycle while the
// queue is not full. The two-entry queue separates the parser from the output.
// When the receiver stalls, the queue fills and s_axis_tready falls once both
// entries are held, whether or not the next input would produce a result.
// Reset clears the frame state and the queue, and loads header byte 0x55 and
// largest payload length 64.
module crc8_packet_deframer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [crc8pd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // rx_byte
  input  logic                           s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // payload_byte, byte_index, frame_length, command, received_crc, computed_crc
  output logic [47:0]                    m_axis_tdata,
  output logic [1:0]                     m_axis_tuser   // event_res
);
  import crc8pd_pkg::*;

  logic    push;
  logic    q_ready;
  result_t front_res;
  result_t q_res;

  crc8pd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (q_ready),
    .in_kind_i   (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .push_o      (push),
    .res_o       (front_res)
  );

  crc8pd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (front_res),
    .ready_o     (q_ready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (q_res)
  );

  assign s_axis_tready = q_ready;
  assign m_axis_tuser  = q_res.event_res;
  assign m_axis_tdata  = {q_res.computed_crc, q_res.received_crc, q_res.command,
                          q_res.frame_length, q_res.byte_index, q_res.payload_byte};

endmodule
